@@ rtl/crc32b_pkg.sv @@
// Shared constants, types and the CRC table function for the byte-wise CRC-32 engine.
// No dependencies; the step module and the top level import this package.
`default_nettype none

package crc32b_pkg;

  localparam int CRC_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam crc_t KEY_STANDARD  = 32'hEDB88320;
  localparam crc_t KEY_ALTERNATE = 32'h04C11DB7;
  localparam crc_t CRC_INIT      = 32'hFFFFFFFF;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_POLY_SELECT = 1'b0;

  // Controls that go with one byte into the update step.
  typedef struct packed {
    logic first_byte;
    logic poly_sel;
  } step_ctl_t;

  // Contents of the input register.
  typedef struct packed {
    byte_t     data_byte;
    logic      last_byte;
    step_ctl_t ctl;
  } in_req_t;

  // One table entry: eight conditional shift-xor steps with the chosen key.
  function automatic crc_t table_entry(input byte_t idx, input crc_t key);
    crc_t v;
    v = {{(CRC_W-BYTE_W){1'b0}}, idx};
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ key;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/crc32b_if.sv @@
// Stream interfaces of the CRC engine: the byte request channel and the result channel.
// Stand-alone; widths follow the fixed field widths of the block.
`default_nettype none

interface crc32b_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output first_byte, output last_byte,
                 input ready);
  modport sink(input valid, input data_byte, input first_byte, input last_byte,
               output ready);
endinterface

interface crc32b_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source(output valid, output crc_value, input ready);
  modport sink(input valid, input crc_value, output ready);
endinterface

`default_nettype wire

@@ rtl/crc32b_step.sv @@
// One byte update of the reflected CRC register: reload, index, table lookup and xor.
// Depends on crc32b_pkg for the keys, the init value and the table function.
`default_nettype none

module crc32b_step (
  input  wire crc32b_pkg::crc_t      crc_in,
  input  wire crc32b_pkg::byte_t     data_byte,
  input  wire crc32b_pkg::step_ctl_t ctl,
  output crc32b_pkg::crc_t           crc_out
);
  import crc32b_pkg::*;

  crc_t  crc_base;
  crc_t  key;
  byte_t idx;

  always_comb begin
    crc_base = ctl.first_byte ? CRC_INIT : crc_in;
    key      = ctl.poly_sel ? KEY_ALTERNATE : KEY_STANDARD;
    idx      = data_byte ^ crc_base[BYTE_W-1:0];
    crc_out  = (crc_base >> BYTE_W) ^ table_entry(idx, key);
  end

endmodule

`default_nettype wire

@@ rtl/crc32_byte_engine_two_poly.sv @@
// Top level of the byte-wise CRC-32 engine with two selectable keys.
// Depends on crc32b_pkg, the stream interfaces in crc32b_if and crc32b_step.
`default_nettype none

// The engine takes one message byte per request on the byte channel and keeps a
// 32-bit reflected CRC register. A request with first_byte set restarts the
// register from all ones before its byte is folded in; a request with last_byte
// set produces one result, the inverted register, on the result channel. Bytes
// without first_byte continue from the register as it stands, also after a
// finished message. The poly_select register (byte address 0) picks the key:
// 0 gives the standard CRC-32 key 0xEDB88320, 1 gives 0x04C11DB7 in the same
// right-shifting form. Write poly_select only while the engine is idle.
// Throughput is one byte per clock cycle while the byte channel is not held
// off: a request sits in the input register while the combinational table
// step updates the CRC register, so consecutive bytes of a message can be
// taken in consecutive cycles. The byte channel holds off only when a last
// byte is in the input register and the result register is still full and
// not being taken.
module crc32_byte_engine_two_poly (
  input  wire                                 clk,
  input  wire                                 rst,
  crc32b_byte_if.sink                         bytes,
  crc32b_result_if.source                     results,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [crc32b_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire [crc32b_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [crc32b_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);
  import crc32b_pkg::*;

  // Configuration register.
  logic poly_select;
  logic cfg_write;
  logic cfg_index;

  // Input register stage.
  logic    in_valid;
  in_req_t in_req;

  // CRC register and result register.
  crc_t crc_state;
  crc_t crc_next;
  logic res_valid;
  crc_t res_value;

  logic advance;
  logic res_free;

  assign pready    = 1'b1;
  assign cfg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (cfg_index)
      REG_POLY_SELECT: prdata = {{(CFG_DATA_W-1){1'b0}}, poly_select};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_select <= 1'b0;
    end else if (cfg_write && (cfg_index == REG_POLY_SELECT)) begin
      poly_select <= pwdata[0];
    end
  end

  // The result register is free when empty or when its result is taken now.
  assign res_free = !res_valid || results.ready;
  // A byte that does not end a message never waits on the result side.
  assign advance  = in_valid && (!in_req.last_byte || res_free);
  assign bytes.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  // The key choice is latched with the byte; the user changes configuration only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_req.data_byte      <= bytes.data_byte;
      in_req.last_byte      <= bytes.last_byte;
      in_req.ctl.first_byte <= bytes.first_byte;
      in_req.ctl.poly_sel   <= poly_select;
    end
  end

  crc32b_step u_step (
    .crc_in    (crc_state),
    .data_byte (in_req.data_byte),
    .ctl       (in_req.ctl),
    .crc_out   (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_state <= CRC_INIT;
    end else if (advance) begin
      crc_state <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_req.last_byte) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_req.last_byte) begin
      res_value <= ~crc_next;
    end
  end

  assign results.valid     = res_valid;
  assign results.crc_value = res_value;

endmodule

`default_nettype wire

@@ rtl/crc32b_checker.sv @@
// Port-level checks for the CRC engine, attached to the top level by a bind statement.
// Depends only on the top level's port signals.
`default_nettype none

module crc32b_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_last,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_value,
  input wire        pready
);

  // A stalled result keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // A new result appears only after a last byte was taken.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a matching last byte");

  // The byte channel stalls only behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("byte channel stalled without result backpressure");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind crc32_byte_engine_two_poly crc32b_checker u_crc32b_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bytes.valid),
  .in_ready  (bytes.ready),
  .in_last   (bytes.last_byte),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.crc_value),
  .pready    (pready)
);

`default_nettype wire
